@@ hdl/pav_pkg.sv @@
// ----------------------------------------------------------------------------
// pav_pkg
// Types, constants and a helper shared by the archive header validator.
// ----------------------------------------------------------------------------
package pav_pkg;

	localparam int unsigned MAX_BANNER_DEF  = 4096;
	localparam int unsigned MAX_MEMBERS_DEF = 65535;
	localparam int unsigned TAIL_BYTES      = 24;
	localparam int unsigned MIN_SPAN        = 20;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_BLEN, PH_BTEXT, PH_FLAG, PH_COUNT,
		PH_NLEN, PH_NAME, PH_TAIL, PH_PENDING
	} phase_t;

	typedef enum logic [3:0] {
		ERR_OK       = 4'd0,
		ERR_SHORT    = 4'd1,
		ERR_SIG      = 4'd2,
		ERR_BLEN     = 4'd3,
		ERR_BBYTE    = 4'd4,
		ERR_COUNT    = 4'd5,
		ERR_EMPTY    = 4'd6,
		ERR_NAME     = 4'd7,
		ERR_NEG      = 4'd8,
		ERR_OUTSIDE  = 4'd9,
		ERR_TILING   = 4'd10,
		ERR_ESTREAM  = 4'd11,
		ERR_TRUNC    = 4'd12,
		ERR_PASTEND  = 4'd13
	} err_t;

	localparam logic [7:0] MAGIC [0:6] = '{8'h4A, 8'h47, 8'h50, 8'h41, 8'h4B, 8'h00, 8'h01};

	// Does a run of len bytes starting at off fit inside span?
	function automatic logic fits_span(input logic [39:0] off, input logic [32:0] len,
			input logic [39:0] span);
		logic [40:0] sum;
		sum = {1'b0, off} + {8'd0, len};
		return sum <= {1'b0, span};
	endfunction

endpackage

@@ hdl/pav_if.sv @@
// ----------------------------------------------------------------------------
// pav_in_if / pav_out_if
// Valid/ready channels for archive bytes and for member/verdict items.
// ----------------------------------------------------------------------------
interface pav_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;
	modport source (output valid, op, data_byte, input ready);
	modport sink   (input valid, op, data_byte, output ready);
endinterface

interface pav_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] member_index;
	logic [39:0] rec_pos;
	logic [7:0]  name_length;
	logic [31:0] timestamp;
	logic [30:0] plain_len;
	logic [30:0] stream_start;
	logic [30:0] stream_len;
	logic        accepted;
	logic [3:0]  error_code;
	logic [39:0] arc_extent;
	logic [15:0] total_members;
	modport source (output valid, kind, member_index, rec_pos, name_length, timestamp,
		plain_len, stream_start, stream_len, accepted, error_code,
		arc_extent, total_members, input ready);
	modport sink   (input valid, kind, member_index, rec_pos, name_length, timestamp,
		plain_len, stream_start, stream_len, accepted, error_code,
		arc_extent, total_members, output ready);
endinterface

@@ hdl/pak_archive_header_validator.sv @@
// ----------------------------------------------------------------------------
// pak_archive_header_validator
// Streaming header and directory checker for a packed archive container.
// ----------------------------------------------------------------------------
// Feed the archive one byte per item from offset 0 (op 0); op 1 restarts
// parsing and keeps archive_span. Every item is handled by the parse logic
// that sits in front of a single result register, so one item is taken
// per clock as long as the result register is empty or being drained in
// the same cycle. A member record comes out at the last tail byte of each
// directory record; the verdict follows on an error, at the last count byte
// when the member count is zero, or on the byte after the last record. After
// the verdict, bytes are dropped until a restart. Write archive_span only while the block is idle.
module pak_archive_header_validator import pav_pkg::*; #(
	parameter int unsigned MAX_BANNER  = MAX_BANNER_DEF,
	parameter int unsigned MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [39:0] cfg_wdata,
	pav_in_if.sink      item_in,
	pav_out_if.source   res_out
);

	logic [39:0]  span_q;
	phase_t       phase_q, phase_n;
	logic [7:0]   pos_q, pos_n;
	logic [31:0]  acc_q, acc_n;
	logic [39:0]  off_q, off_n;
	logic         banner_q, banner_n;
	logic [7:0]   nlen_q, nlen_n;
	logic [1:0]   dots_q, dots_n;
	logic [16:0]  total_q, total_n;
	logic [16:0]  seen_q, seen_n;
	logic [127:0] tail_q, tail_n;
	logic [30:0]  first_q, first_n;
	logic [32:0]  end_q, end_n;
	logic         fin_q, fin_n;

	logic         take;
	logic         do_v, do_m;
	err_t         v_code;
	logic [39:0]  v_size;
	logic [7:0]   b;
	logic [39:0]  nxt;
	logic [31:0]  usz, doff, csz;
	logic [30:0]  first_c;
	logic [32:0]  end_c;
	logic [39:0]  rec_c;

	// Result register
	logic         ov_q;
	logic         kind_q, acc_ok_q;
	logic [15:0]  midx_q, mcnt_q;
	logic [39:0]  roff_q, asize_q;
	logic [7:0]   nl_q;
	logic [31:0]  ts_q;
	logic [30:0]  usz_q, doff_q, csz_q;
	err_t         ec_q;

	assign item_in.ready = !ov_q || res_out.ready;
	assign take = item_in.valid && item_in.ready;
	assign b = item_in.data_byte;
	assign nxt = off_q + 40'd1;

	assign usz   = tail_q[63:32];
	assign doff  = tail_q[95:64];
	assign csz   = tail_q[127:96];
	assign first_c = (seen_q == 17'd0) ? doff[30:0] : first_q;
	assign end_c   = {1'b0, doff} + {1'b0, csz};
	assign rec_c   = off_q - 40'(nlen_q) - 40'(TAIL_BYTES);

	// Parse one byte
	always_comb begin
		phase_n = phase_q; pos_n = pos_q; acc_n = acc_q; off_n = off_q;
		banner_n = banner_q; nlen_n = nlen_q; dots_n = dots_q; total_n = total_q;
		seen_n = seen_q; tail_n = tail_q; first_n = first_q; end_n = end_q;
		fin_n = fin_q;
		do_v = 1'b0; do_m = 1'b0; v_code = ERR_OK; v_size = '0;
		if (item_in.op) begin
			phase_n = PH_MAGIC; pos_n = '0; acc_n = '0; off_n = '0; banner_n = 1'b0;
			nlen_n = '0; dots_n = '0; total_n = '0; seen_n = '0; tail_n = '0;
			first_n = '0; end_n = '0; fin_n = 1'b0;
		end else if (!fin_q) begin
			off_n = nxt;
			case (phase_q)
				PH_MAGIC: begin
					if (off_q == 40'd0 && span_q < 40'(MIN_SPAN)) begin
						do_v = 1'b1; v_code = ERR_SHORT;
					end else if (b != MAGIC[pos_q[2:0]]) begin
						do_v = 1'b1; v_code = ERR_SIG;
					end else if (pos_q == 8'd6) begin
						pos_n = '0; acc_n = '0;
						if (!fits_span(nxt, 33'd4, span_q)) begin
							do_v = 1'b1; v_code = ERR_TRUNC;
						end else begin
							phase_n = PH_BLEN;
						end
					end else begin
						pos_n = pos_q + 8'd1;
					end
				end
				PH_BLEN, PH_COUNT: begin
					acc_n = acc_q | (32'(b) << {pos_q[1:0], 3'b000});
					pos_n = pos_q + 8'd1;
					if (pos_q[1:0] == 2'd3) begin
						if (phase_q == PH_BLEN) begin
							if (acc_n[31] || acc_n > 32'(MAX_BANNER)) begin
								do_v = 1'b1; v_code = ERR_BLEN;
							end else if (!fits_span(nxt, {1'b0, acc_n}, span_q)) begin
								do_v = 1'b1; v_code = ERR_TRUNC;
							end else if (acc_n != 32'd0) begin
								phase_n = PH_BTEXT;
							end else begin
								pos_n = '0; acc_n = '0;
								if (!fits_span(nxt, banner_q ? 33'd5 : 33'd4, span_q)) begin
									do_v = 1'b1; v_code = ERR_TRUNC;
								end
								phase_n = banner_q ? PH_FLAG : PH_BLEN;
								banner_n = 1'b1;
							end
						end else begin
							if (acc_n[31] || acc_n > 32'(MAX_MEMBERS)) begin
								do_v = 1'b1; v_code = ERR_COUNT;
							end else begin
								total_n = 17'(acc_n);
								if (acc_n == 32'd0) begin
									do_v = 1'b1; v_code = ERR_OK; v_size = nxt;
								end else if (!fits_span(nxt, 33'd1, span_q)) begin
									do_v = 1'b1; v_code = ERR_TRUNC;
								end else begin
									phase_n = PH_NLEN;
								end
							end
						end
					end
				end
				PH_BTEXT: begin
					if (b < 8'h20 && b != 8'h09) begin
						do_v = 1'b1; v_code = ERR_BBYTE;
					end else begin
						acc_n = acc_q - 32'd1;
						if (acc_n == 32'd0) begin
							pos_n = '0;
							if (!fits_span(nxt, banner_q ? 33'd5 : 33'd4, span_q)) begin
								do_v = 1'b1; v_code = ERR_TRUNC;
							end
							phase_n = banner_q ? PH_FLAG : PH_BLEN;
							banner_n = 1'b1;
						end
					end
				end
				PH_FLAG: begin
					phase_n = PH_COUNT; pos_n = '0; acc_n = '0;
				end
				PH_NLEN: begin
					if (b == 8'd0) begin
						do_v = 1'b1; v_code = ERR_EMPTY;
					end else if (!fits_span(nxt, 33'(b) + 33'(TAIL_BYTES), span_q)) begin
						do_v = 1'b1; v_code = ERR_TRUNC;
					end else begin
						nlen_n = b; pos_n = '0; dots_n = '0; phase_n = PH_NAME;
					end
				end
				PH_NAME: begin
					if (b < 8'h20 || b inside {8'h2F, 8'h5C, 8'h3A, 8'h2A, 8'h22, 8'h3C,
							8'h3E, 8'h7C, 8'h3F}) begin
						do_v = 1'b1; v_code = ERR_NAME;
					end else begin
						if (b == 8'h2E && pos_q == 8'd0) dots_n[0] = 1'b1;
						if (b == 8'h2E && pos_q == 8'd1) dots_n[1] = 1'b1;
						pos_n = pos_q + 8'd1;
						if (pos_n == nlen_q) begin
							if ((nlen_q == 8'd1 && dots_n[0]) ||
									(nlen_q == 8'd2 && dots_n == 2'b11)) begin
								do_v = 1'b1; v_code = ERR_NAME;
							end else begin
								pos_n = '0; tail_n = '0; phase_n = PH_TAIL;
							end
						end
					end
				end
				PH_TAIL: begin
					if (pos_q < 8'd16) tail_n[{pos_q[3:0], 3'b000} +: 8] = b;
					pos_n = pos_q + 8'd1;
					if (pos_q == 8'(TAIL_BYTES - 1)) begin
						pos_n = '0;
						if (usz[31] || doff[31] || csz[31]) begin
							do_v = 1'b1; v_code = ERR_NEG;
						end else if (!fits_span(40'(doff), 33'(csz), span_q)) begin
							do_v = 1'b1; v_code = ERR_OUTSIDE;
						end else if (seen_q != 17'd0 && 33'(doff) != end_q) begin
							do_v = 1'b1; v_code = ERR_TILING;
						end else if (csz == 32'd0) begin
							do_v = 1'b1; v_code = ERR_ESTREAM;
						end else begin
							first_n = first_c;
							end_n = end_c;
							if (seen_q + 17'd1 >= total_q) begin
								if (40'(first_c) != nxt) begin
									do_v = 1'b1; v_code = ERR_TILING;
								end else if (40'(end_c) > span_q) begin
									do_v = 1'b1; v_code = ERR_PASTEND;
								end else begin
									phase_n = PH_PENDING;
								end
							end else begin
								phase_n = PH_NLEN;
							end
							if (!do_v) begin
								do_m = 1'b1;
								seen_n = seen_q + 17'd1;
							end
						end
					end
				end
				PH_PENDING: begin
					do_v = 1'b1; v_code = ERR_OK; v_size = 40'(end_q);
				end
				default: begin
					do_v = 1'b1; v_code = ERR_SIG;
				end
			endcase
			if (do_v) fin_n = 1'b1;
		end
	end

	// Parse state; restart and reset clear it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= '0; phase_q <= PH_MAGIC; pos_q <= '0; acc_q <= '0; off_q <= '0;
			banner_q <= 1'b0; nlen_q <= '0; dots_q <= '0; total_q <= '0; seen_q <= '0;
			tail_q <= '0; first_q <= '0; end_q <= '0; fin_q <= 1'b0;
		end else begin
			if (cfg_we) span_q <= cfg_wdata;
			if (take) begin
				phase_q <= phase_n; pos_q <= pos_n; acc_q <= acc_n; off_q <= off_n;
				banner_q <= banner_n; nlen_q <= nlen_n; dots_q <= dots_n;
				total_q <= total_n; seen_q <= seen_n; tail_q <= tail_n;
				first_q <= first_n; end_q <= end_n; fin_q <= fin_n;
			end
		end
	end

	// Result register: load on a producing item, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (take && (do_v || do_m)) begin
			ov_q <= 1'b1;
		end else if (res_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (do_v || do_m)) begin
			kind_q   <= do_v;
			midx_q   <= do_m ? seen_q[15:0] : '0;
			roff_q   <= do_m ? rec_c : '0;
			nl_q     <= do_m ? nlen_q : '0;
			ts_q     <= do_m ? tail_q[31:0] : '0;
			usz_q    <= do_m ? usz[30:0] : '0;
			doff_q   <= do_m ? doff[30:0] : '0;
			csz_q    <= do_m ? csz[30:0] : '0;
			acc_ok_q <= do_v && v_code == ERR_OK;
			ec_q     <= do_v ? v_code : ERR_OK;
			asize_q  <= (do_v && v_code == ERR_OK) ? v_size : '0;
			mcnt_q   <= do_v ? total_n[15:0] : '0;
		end
	end

	assign res_out.valid         = ov_q;
	assign res_out.kind          = kind_q;
	assign res_out.member_index  = midx_q;
	assign res_out.rec_pos       = roff_q;
	assign res_out.name_length   = nl_q;
	assign res_out.timestamp     = ts_q;
	assign res_out.plain_len     = usz_q;
	assign res_out.stream_start  = doff_q;
	assign res_out.stream_len    = csz_q;
	assign res_out.accepted      = acc_ok_q;
	assign res_out.error_code    = ec_q;
	assign res_out.arc_extent    = asize_q;
	assign res_out.total_members = mcnt_q;

endmodule

@@ verif/pav_checker.sv @@
// ----------------------------------------------------------------------------
// pav_checker
// Watches the byte and result channels of the archive header validator,
// predicts every member record and verdict, and compares them in order.
// ----------------------------------------------------------------------------
module pav_checker import pav_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [39:0] cfg_wdata,
	pav_in_if           items,
	pav_out_if          results,
	output int          fail_count,
	output int          waiting,
	output int          member_records,
	output int          verdicts_ok,
	output logic [15:0] codes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        kind;
		logic [15:0] member_index;
		logic [39:0] rec_pos;
		logic [7:0]  name_length;
		logic [31:0] timestamp;
		logic [30:0] plain_len;
		logic [30:0] stream_start;
		logic [30:0] stream_len;
		logic        accepted;
		logic [3:0]  error_code;
		logic [39:0] arc_extent;
		logic [15:0] total_members;
	} pav_result_t;

	localparam logic [7:0] SIG [0:6] = '{8'h4A, 8'h47, 8'h50, 8'h41, 8'h4B, 8'h00, 8'h01};

	pav_result_t expected_q[$];

	// predictor state
	logic [39:0] span;
	phase_t      ph;
	int unsigned pos;
	logic [31:0] acc;
	logic [39:0] boff;
	bit          second_banner;
	int unsigned nlen;
	logic [1:0]  dots;
	logic [31:0] mtotal;
	logic [31:0] mseen;
	logic [63:0] tail0, tail1;
	logic [63:0] first_off;
	logic [63:0] chain_end;
	bit          done;

	function automatic void clear_archive();
		ph = PH_MAGIC; pos = 0; acc = '0; boff = '0; second_banner = 0;
		nlen = 0; dots = '0; mtotal = '0; mseen = '0; tail0 = '0; tail1 = '0;
		first_off = '0; chain_end = '0; done = 0;
	endfunction

	function automatic bit fits(logic [63:0] off, logic [63:0] len);
		return off <= span && len <= span - off;
	endfunction

	function automatic bit give_verdict(err_t code, logic [63:0] size, output pav_result_t r);
		r = '0;
		r.kind = 1'b1;
		r.accepted = (code == ERR_OK);
		r.error_code = code;
		r.arc_extent = (code == ERR_OK) ? size[39:0] : '0;
		r.total_members = mtotal[15:0];
		done = 1;
		return 1;
	endfunction

	function automatic bit end_banner(logic [63:0] nxt, output pav_result_t r);
		pos = 0; acc = '0;
		if (!second_banner) begin
			second_banner = 1;
			if (!fits(nxt, 4)) return give_verdict(ERR_TRUNC, 0, r);
			ph = PH_BLEN;
		end else begin
			if (!fits(nxt, 5)) return give_verdict(ERR_TRUNC, 0, r);
			ph = PH_FLAG;
		end
		return 0;
	endfunction

	function automatic bit end_record(logic [63:0] off, output pav_result_t r);
		logic [63:0] usz, doff, csz, rec;
		usz = tail0[63:32];
		doff = tail1[31:0];
		csz = tail1[63:32];
		rec = off - (nlen + TAIL_BYTES);
		if (usz[31] || doff[31] || csz[31]) return give_verdict(ERR_NEG, 0, r);
		if (!fits(doff, csz)) return give_verdict(ERR_OUTSIDE, 0, r);
		if (mseen > 0 && doff != chain_end) return give_verdict(ERR_TILING, 0, r);
		if (csz == 0) return give_verdict(ERR_ESTREAM, 0, r);
		if (mseen == 0) first_off = doff;
		chain_end = doff + csz;
		if (mseen + 1 >= mtotal) begin
			if (first_off != off + 1) return give_verdict(ERR_TILING, 0, r);
			if (chain_end > span) return give_verdict(ERR_PASTEND, 0, r);
			ph = PH_PENDING;
		end else begin
			ph = PH_NLEN;
		end
		r = '0;
		r.member_index = mseen[15:0];
		r.rec_pos = rec[39:0];
		r.name_length = nlen[7:0];
		r.timestamp = tail0[31:0];
		r.plain_len = usz[30:0];
		r.stream_start = doff[30:0];
		r.stream_len = csz[30:0];
		mseen++;
		return 1;
	endfunction

	// Advance the parse by one archive byte; return 1 when a result is due.
	function automatic bit parse_byte(logic [7:0] b, output pav_result_t r);
		logic [63:0] off;
		off = boff;
		r = '0;
		case (ph)
			PH_MAGIC: begin
				if (off == 0 && span < MIN_SPAN) return give_verdict(ERR_SHORT, 0, r);
				if (pos >= 7 || b != SIG[pos]) return give_verdict(ERR_SIG, 0, r);
				pos++;
				if (pos == 7) begin
					pos = 0; acc = '0;
					if (!fits(off + 1, 4)) return give_verdict(ERR_TRUNC, 0, r);
					ph = PH_BLEN;
				end
				return 0;
			end
			PH_BLEN: begin
				acc |= 32'(b) << (8 * (pos & 3));
				pos++;
				if (pos < 4) return 0;
				if (acc[31] || acc > MAX_BANNER_DEF) return give_verdict(ERR_BLEN, 0, r);
				if (!fits(off + 1, acc)) return give_verdict(ERR_TRUNC, 0, r);
				if (acc == 0) return end_banner(off + 1, r);
				ph = PH_BTEXT;
				return 0;
			end
			PH_BTEXT: begin
				if (b < 8'h20 && b != 8'h09) return give_verdict(ERR_BBYTE, 0, r);
				acc--;
				if (acc == 0) return end_banner(off + 1, r);
				return 0;
			end
			PH_FLAG: begin
				ph = PH_COUNT; pos = 0; acc = '0;
				return 0;
			end
			PH_COUNT: begin
				acc |= 32'(b) << (8 * (pos & 3));
				pos++;
				if (pos < 4) return 0;
				if (acc[31] || acc > MAX_MEMBERS_DEF) return give_verdict(ERR_COUNT, 0, r);
				mtotal = acc;
				if (mtotal == 0) return give_verdict(ERR_OK, off + 1, r);
				if (!fits(off + 1, 1)) return give_verdict(ERR_TRUNC, 0, r);
				ph = PH_NLEN;
				return 0;
			end
			PH_NLEN: begin
				if (b == 0) return give_verdict(ERR_EMPTY, 0, r);
				if (!fits(off + 1, 64'(b) + TAIL_BYTES)) return give_verdict(ERR_TRUNC, 0, r);
				nlen = b; pos = 0; dots = '0;
				ph = PH_NAME;
				return 0;
			end
			PH_NAME: begin
				if (b < 8'h20 || b == "/" || b == "\\" || b == ":" || b == "*" || b == "\"" ||
						b == "<" || b == ">" || b == "|" || b == "?")
					return give_verdict(ERR_NAME, 0, r);
				if (b == "." && pos < 2) dots[pos] = 1'b1;
				pos++;
				if (pos < nlen) return 0;
				// "." and ".." are refused once the whole name is in
				if ((nlen == 1 && dots[0]) || (nlen == 2 && dots == 2'b11))
					return give_verdict(ERR_NAME, 0, r);
				pos = 0; tail0 = '0; tail1 = '0;
				ph = PH_TAIL;
				return 0;
			end
			PH_TAIL: begin
				if (pos < 8) tail0 |= 64'(b) << (8 * pos);
				else if (pos < 16) tail1 |= 64'(b) << (8 * (pos - 8));
				pos++;
				if (pos < TAIL_BYTES) return 0;
				pos = 0;
				return end_record(off, r);
			end
			PH_PENDING: return give_verdict(ERR_OK, chain_end, r);
			default: return give_verdict(ERR_SIG, 0, r);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pav_result_t exp_r, got;
		if (!arst_n) begin
			span = '0;
			clear_archive();
			expected_q.delete();
			fail_count <= 0;
			member_records <= 0;
			verdicts_ok <= 0;
			codes_seen <= '0;
		end else begin
			if (cfg_we) span = cfg_wdata;
			if (results.valid && results.ready) begin
				got = {results.kind, results.member_index, results.rec_pos,
					results.name_length, results.timestamp, results.plain_len,
					results.stream_start, results.stream_len, results.accepted,
					results.error_code, results.arc_extent, results.total_members};
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %p", got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						if (fail_count < 10) $display("mismatch\n  expected %p\n  actual   %p",
							exp_r, got);
						fail_count <= fail_count + 1;
					end
				end
				if (got.kind) begin
					codes_seen[got.error_code] <= 1'b1;
					if (got.accepted) verdicts_ok <= verdicts_ok + 1;
				end else begin
					member_records <= member_records + 1;
				end
			end
			if (items.valid && items.ready) begin
				if (items.op) clear_archive();
				else if (!done) begin
					if (parse_byte(items.data_byte, exp_r)) expected_q.push_back(exp_r);
					boff = boff + 1;
				end
			end
		end
	end

	assign waiting = expected_q.size();

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the archive header validator with directed defects and random
// archives over several archive_span settings, with random stalls on both
// channels; pav_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import pav_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          IDLE_LIMIT = 5000;
	localparam logic [39:0] SPAN_MAX   = 40'hFF_FFFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [39:0] cfg_wdata = '0;

	pav_in_if  item_if ();
	pav_out_if res_if ();

	int          fail_count, waiting, member_records, verdicts_ok;
	logic [15:0] codes_seen;
	int          items_sent;
	int          in_gap_max, out_gap_max;
	int          idle_cycles;
	logic [7:0]  arc[$];

	pak_archive_header_validator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item_in(item_if), .res_out(res_if)
	);

	pav_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.items(item_if), .results(res_if), .fail_count(fail_count), .waiting(waiting),
		.member_records(member_records), .verdicts_ok(verdicts_ok), .codes_seen(codes_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hold every input at a known value before the first edge.
	initial begin
		item_if.valid = 1'b0;
		item_if.op = 1'b0;
		item_if.data_byte = '0;
		res_if.ready = 1'b0;
	end

	// Result side: stall for a drawn number of cycles, then hold ready until
	// a result goes through.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	// Watchdog: give up when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Present one item after a drawn gap and return at the edge it is taken.
	// A zero gap keeps valid high so back-to-back items stream.
	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.op <= op;
		item_if.data_byte <= b;
		do @(posedge clk); while (!item_if.ready);
		items_sent++;
	endtask

	// Drain: drop valid, wait until every expected result has been taken and
	// the result register is empty, then idle before touching archive_span.
	task automatic settle();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0 || res_if.valid) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_span(input logic [39:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void push_le(logic [31:0] v, int n);
		for (int i = 0; i < n; i++) arc.push_back(v[8*i +: 8]);
	endfunction

	function automatic logic [7:0] name_char();
		return ($urandom_range(0, 6) == 0) ? 8'h2E : 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	// Build a well-formed archive with nmem members, then plant the named
	// defect in it. Streams tile right after the directory.
	function automatic void build_archive(err_t defect, int nmem);
		string       bad_chars;
		int          nl[$];
		int          blen, dir_end, victim, which;
		logic [31:0] fld, usz, doff, csz;
		bad_chars = "/\\:*?\"<>|";
		arc.delete();
		if (nmem == 0 && defect inside {ERR_EMPTY, ERR_NAME, ERR_NEG, ERR_TILING, ERR_ESTREAM})
			nmem = 1;
		for (int i = 0; i < 7; i++) arc.push_back(MAGIC[i]);
		if (defect == ERR_SIG) begin
			which = $urandom_range(0, 6);
			arc[which] = arc[which] ^ (8'h01 << $urandom_range(0, 7));
		end
		victim = $urandom_range(0, 1);
		for (int k = 0; k < 2; k++) begin
			blen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
			if (defect == ERR_BBYTE && k == victim && blen == 0) blen = 3;
			fld = blen;
			if (defect == ERR_BLEN && k == victim)
				fld = $urandom_range(0, 1) ? 32'(4097 + $urandom_range(0, 60000))
					: (32'h8000_0000 | $urandom());
			push_le(fld, 4);
			which = $urandom_range(0, blen - 1);
			for (int i = 0; i < blen; i++) begin
				if (defect == ERR_BBYTE && k == victim && i == which) begin
					do fld[7:0] = $urandom_range(0, 31); while (fld[7:0] == 8'h09);
					arc.push_back(fld[7:0]);
				end else begin
					arc.push_back($urandom_range(0, 15) == 0 ? 8'h09 : 8'($urandom_range(32, 255)));
				end
			end
		end
		arc.push_back(8'($urandom()));
		fld = nmem;
		if (defect == ERR_COUNT)
			fld = $urandom_range(0, 1) ? 32'(65536 + $urandom_range(0, 1000))
				: (32'h8000_0000 | $urandom());
		push_le(fld, 4);
		dir_end = arc.size();
		victim = $urandom_range(0, nmem - 1);
		which = $urandom_range(0, 2);
		for (int m = 0; m < nmem; m++) begin
			nl.push_back($urandom_range(0, 7) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 6));
			if (defect == ERR_NAME && m == victim && which < 2) nl[m] = which + 1;
			dir_end += 1 + nl[m] + TAIL_BYTES;
		end
		doff = dir_end;
		for (int m = 0; m < nmem; m++) begin
			arc.push_back((defect == ERR_EMPTY && m == victim) ? 8'h00 : 8'(nl[m]));
			for (int i = 0; i < nl[m]; i++) begin
				if (defect == ERR_NAME && m == victim && which < 2)
					arc.push_back(8'h2E);
				else if (defect == ERR_NAME && m == victim && i == nl[m] - 1)
					arc.push_back($urandom_range(0, 1) ? bad_chars[$urandom_range(0, 8)]
						: 8'($urandom_range(0, 31)));
				else
					arc.push_back(name_char());
			end
			usz = $urandom() & 32'h7FFF_FFFF;
			if (defect == ERR_NEG && m == victim) usz[31] = 1'b1;
			csz = ($urandom_range(0, 15) == 0) ? ($urandom() & 32'h7FFF_FFFF)
				: 32'($urandom_range(1, 300));
			if (defect == ERR_ESTREAM && m == victim) csz = 0;
			if (defect == ERR_TILING && m == victim) doff = $urandom_range(0, 1) ? doff + 1 : doff - 1;
			push_le($urandom(), 4);
			push_le(usz, 4);
			push_le(doff, 4);
			push_le(csz, 4);
			push_le($urandom(), 4);
			push_le($urandom(), 4);
			doff = doff + csz;
		end
		// the first stream bytes: with members and no defect, the first one draws the accepting verdict
		repeat ($urandom_range(1, 4)) arc.push_back(8'($urandom()));
	endfunction

	task automatic send_archive();
		int cut;
		// now and then abandon the archive partway with a restart
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, arc.size()) : arc.size();
		send_item(1'b1, 8'($urandom()));
		for (int i = 0; i < cut; i++) send_item(1'b0, arc[i]);
	endtask

	function automatic void draw_idling();
		int pick;
		pick = $urandom_range(0, 2);
		in_gap_max = (pick == 0) ? 0 : (pick == 1 ? 3 : 19);
		pick = $urandom_range(0, 2);
		out_gap_max = (pick == 0) ? 0 : (pick == 1 ? 3 : 19);
	endfunction

	initial begin
		logic [39:0] spans[$];
		err_t        defects[$];
		err_t        pick;
		int          phase_start;
		idle_cycles = 0;
		items_sent = 0;
		in_gap_max = 0;
		out_gap_max = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every defect the builder can plant, plus empty and good
		// archives, with plenty of room in archive_span. Member defects get
		// one member, header defects none.
		write_span(SPAN_MAX);
		defects = '{ERR_OK, ERR_SIG, ERR_BLEN, ERR_BBYTE, ERR_COUNT, ERR_EMPTY, ERR_NAME,
			ERR_NAME, ERR_NAME, ERR_NEG, ERR_TILING, ERR_TILING, ERR_ESTREAM};
		build_archive(ERR_OK, 2);
		send_archive();
		foreach (defects[i]) begin
			build_archive(defects[i], 0);
			send_archive();
		end

		// Random: a handful of spans, the extremes among them; the small ones
		// drive the short-file, truncation and outside-span checks.
		spans = '{40'd0, 40'd19, 40'd20, 40'd45, 40'd300, 40'd2000, 40'h8000_0000,
			SPAN_MAX, 40'($urandom()) << $urandom_range(0, 8)};
		foreach (spans[s]) begin
			write_span(spans[s]);
			phase_start = items_sent;
			while (items_sent - phase_start < 30) begin
				draw_idling();
				if ($urandom_range(0, 11) == 0) begin
					// noise: raw random bytes after a restart
					send_item(1'b1, 8'($urandom()));
					repeat ($urandom_range(1, 20)) send_item(1'b0, 8'($urandom()));
				end else begin
					pick = ($urandom_range(0, 9) < 5) ? ERR_OK : defects[$urandom_range(1, 12)];
					build_archive(pick, $urandom_range(0, 2));
					send_archive();
				end
			end
		end

		settle();
		$display("sent %0d items over %0d spans; %0d member records, %0d accepted archives",
			items_sent, spans.size() + 1, member_records, verdicts_ok);
		$display("verdict codes seen (bit per code): %b", codes_seen);
		if (fail_count == 0 && waiting == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, waiting);
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ pak_archive_header_validator.f @@
hdl/pav_pkg.sv
hdl/pav_if.sv
hdl/pak_archive_header_validator.sv
verif/pav_checker.sv
verif/testbench.sv
